// File: src/pncc_pkg.sv
// shared types and constants of the polygon edge crossing check
`timescale 1ns / 1ps

package pncc_pkg;

   // width of the reported vertex total
   localparam int TOTAL_BITS = 9;

   // a crossing test needs at least this many stored vertices
   localparam int MIN_TEST_VERTS = 3;

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_FILL_BITS = 2;

   // what the back end has to do with one command
   typedef struct packed {
      logic store;    // write the vertex to the store
      logic scan;     // test the newest edge against the stored edges
      logic dropped;  // vertex discarded, store full
   } cmd_ctrl_type;

endpackage

// File: src/pncc_if.sv
// request and response channel interfaces of the polygon edge crossing check
`timescale 1ns / 1ps

interface pncc_req_if #(parameter int COORD_BITS = 16) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic                         mode;

   modport source (output valid, output vertex_x, output vertex_y, output mode,
                   input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input mode,
                 output ready);
endinterface

interface pncc_rsp_if import pncc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  crosses;
   logic [TOTAL_BITS-1:0] vertex_total;
   logic                  dropped;

   modport source (output valid, output crosses, output vertex_total, output dropped,
                   input ready);
   modport sink (input valid, input crosses, input vertex_total, input dropped,
                 output ready);
endinterface

// File: src/polygon_new_edge_crossing_check_core.sv
// top level of the polygon new-edge crossing check
// a new polygon, a drop or a short polygon gets its result without a scan
// a scanning append reads the stored vertices one at a time, all but the newest
// the back takes no new command while it scans or while its result waits to be taken
// the front keeps accepting into a two-entry command queue while the back scans, until the queue is full
// reset: synchronous, clears count, queue, pipeline and result valid; store not cleared
`timescale 1ns / 1ps

module polygon_new_edge_crossing_check_core import pncc_pkg::*; #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   pncc_req_if.sink    req_bus,
   pncc_rsp_if.source  rsp_bus
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);

   // command channel from front to back
   logic                  cmd_valid;
   logic                  cmd_ready;
   cmd_ctrl_type          cmd_ctrl;
   logic [COORD_BITS-1:0] cmd_x;
   logic [COORD_BITS-1:0] cmd_y;
   logic [AW-1:0]         cmd_idx;
   logic [CNTW-1:0]       cmd_total;

   // front: tracks the vertex count and decides store, scan or drop per transaction
   pncc_front #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_ctrl  (cmd_ctrl),
      .cmd_x     (cmd_x),
      .cmd_y     (cmd_y),
      .cmd_idx   (cmd_idx),
      .cmd_total (cmd_total)
   );

   // back: writes the store, scans stored edges through the orientation pipeline
   // and holds the result until the response transaction completes
   pncc_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_ctrl  (cmd_ctrl),
      .cmd_x     (cmd_x),
      .cmd_y     (cmd_y),
      .cmd_idx   (cmd_idx),
      .cmd_total (cmd_total),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: src/pncc_front.sv
// front end: vertex count, item classification and command queue
`timescale 1ns / 1ps

module pncc_front import pncc_pkg::*; #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   pncc_req_if.sink                               req_bus,
   output logic                                   cmd_valid,
   input  logic                                   cmd_ready,
   output cmd_ctrl_type                           cmd_ctrl,
   output logic [COORD_BITS-1:0]                  cmd_x,
   output logic [COORD_BITS-1:0]                  cmd_y,
   output logic [$clog2(MAX_VERTICES)-1:0]        cmd_idx,
   output logic [$clog2(MAX_VERTICES+1)-1:0]      cmd_total
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);

   logic [CNTW-1:0]            count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QUEUE_FILL_BITS-1:0] fill_ff, fill_in;

   cmd_ctrl_type                q_ctrl_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0]       q_x_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0]       q_y_ff [QUEUE_DEPTH];
   logic [AW-1:0]               q_idx_ff [QUEUE_DEPTH];
   logic [CNTW-1:0]             q_tot_ff [QUEUE_DEPTH];

   cmd_ctrl_type    new_ctrl;
   logic [AW-1:0]   new_idx;
   logic [CNTW-1:0] new_total;
   logic            push, pop;

   assign req_bus.ready = fill_ff != QUEUE_FILL_BITS'(QUEUE_DEPTH);
   assign push = req_bus.valid && req_bus.ready;
   assign cmd_valid = fill_ff != '0;
   assign pop = cmd_valid && cmd_ready;

   // classify against the count as it stands before this vertex
   always_comb begin
      new_ctrl = '0;
      new_idx = '0;
      new_total = count_ff;
      if (req_bus.mode) begin
         new_ctrl.store = 1'b1;
         new_total = CNTW'(1);
      end else if (count_ff == CNTW'(MAX_VERTICES)) begin
         new_ctrl.dropped = 1'b1;
      end else begin
         new_ctrl.store = 1'b1;
         new_idx = count_ff[AW-1:0];
         new_total = count_ff + CNTW'(1);
         new_ctrl.scan = new_total >= CNTW'(MIN_TEST_VERTS);
      end
   end

   always_comb begin
      count_in = push ? new_total : count_ff;
      wptr_in = wptr_ff ^ QUEUE_PTR_BITS'(push);
      rptr_in = rptr_ff ^ QUEUE_PTR_BITS'(pop);
      fill_in = fill_ff + QUEUE_FILL_BITS'(push) - QUEUE_FILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         count_ff <= count_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ctrl_ff[wptr_ff] <= new_ctrl;
         q_x_ff[wptr_ff] <= req_bus.vertex_x;
         q_y_ff[wptr_ff] <= req_bus.vertex_y;
         q_idx_ff[wptr_ff] <= new_idx;
         q_tot_ff[wptr_ff] <= new_total;
      end
   end

   assign cmd_ctrl = q_ctrl_ff[rptr_ff];
   assign cmd_x = q_x_ff[rptr_ff];
   assign cmd_y = q_y_ff[rptr_ff];
   assign cmd_idx = q_idx_ff[rptr_ff];
   assign cmd_total = q_tot_ff[rptr_ff];

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QUEUE_FILL_BITS'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_VERTICES))
      else $error("vertex count beyond store size");

   a_scan_stores: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ctrl.scan |-> cmd_ctrl.store)
      else $error("scan command without a store");
`endif

endmodule

// File: src/pncc_back.sv
// back end: vertex store, edge crossing scan pipeline and result register
`timescale 1ns / 1ps

module pncc_back import pncc_pkg::*; #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cmd_valid,
   output logic                                   cmd_ready,
   input  cmd_ctrl_type                           cmd_ctrl,
   input  logic [COORD_BITS-1:0]                  cmd_x,
   input  logic [COORD_BITS-1:0]                  cmd_y,
   input  logic [$clog2(MAX_VERTICES)-1:0]        cmd_idx,
   input  logic [$clog2(MAX_VERTICES+1)-1:0]      cmd_total,
   pncc_rsp_if.source                             rsp_bus
);

   localparam int CW = COORD_BITS;
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int VW = 2 * CW;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   function automatic logic signed [DW-1:0] dif(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
      return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
   endfunction

   // {positive, negative} sign of p0 - p1
   function automatic logic [1:0] sgn(input logic signed [PW-1:0] p0,
                                      input logic signed [PW-1:0] p1);
      logic signed [SW-1:0] d;
      d = SW'(p0) - SW'(p1);
      return {~d[SW-1] & (d != '0), d[SW-1]};
   endfunction

   function automatic logic opp(input logic [1:0] s, input logic [1:0] t);
      return (s[1] & t[0]) | (s[0] & t[1]);
   endfunction

   logic [VW-1:0] mem [MAX_VERTICES];
   logic [VW-1:0] rdata_ff;

   state_type       state_ff, state_in;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;
   logic [AW-1:0]   last_idx_ff;
   logic [CNTW-1:0] total_ff;
   logic            hit_ff, hit_in, hit_now;
   logic            pop, done, load_direct;

   // newest edge endpoints, its direction, last stored vertex
   logic [CW-1:0]        q1x_ff, q1y_ff, q2x_ff, q2y_ff, prevx_ff, prevy_ff;
   logic signed [DW-1:0] nx_ff, ny_ff;
   logic [CW-1:0]        ux_ff, uy_ff, vjx, vjy;

   logic p1_vld_ff, p1_first_ff, p1_last_ff;
   logic p2_vld_ff, p2_first_ff, p2_last_ff;
   logic p3_vld_ff, p3_first_ff, p3_last_ff;
   logic p4_vld_ff, p4_first_ff, p4_last_ff;

   logic signed [DW-1:0] ex_ff, ey_ff, dx_ff, dy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PW-1:0] pc0_ff, pc1_ff, pa0_ff, pa1_ff, pb0_ff, pb1_ff;
   logic signed [PW-1:0] pc0_in, pc1_in, pa0_in, pa1_in, pb0_in, pb1_in;
   logic [1:0]           c_sg_ff, a_sg_ff, b_sg_ff, cprev_ff;

   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  crosses_ff;
   logic [TOTAL_BITS-1:0] tot_out_ff;
   logic                  dropped_ff;

   assign cmd_ready = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_bus.ready);
   assign pop = cmd_valid && cmd_ready;
   assign load_direct = pop && !cmd_ctrl.scan;
   assign done = p4_vld_ff && p4_last_ff;

   assign hit_now = p4_vld_ff && !p4_first_ff && opp(a_sg_ff, b_sg_ff)
                    && opp(cprev_ff, c_sg_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      rd_idx_in = rd_idx_ff;
      hit_in = hit_ff | hit_now;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               hit_in = 1'b0;
               if (cmd_ctrl.scan) begin
                  state_in = ST_SCAN;
                  rd_idx_in = '0;
               end
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + AW'(1);
            if (rd_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_bus.ready;
      if (load_direct || done) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         p1_vld_ff <= state_ff == ST_SCAN;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         hit_ff <= hit_in;
      end
   end

   // vertex store: one write per storing command, one read per scan cycle
   always_ff @(posedge clock) begin
      if (pop && cmd_ctrl.store) begin
         mem[cmd_idx] <= {cmd_x, cmd_y};
      end
      rdata_ff <= mem[rd_idx_ff];
   end

   // command payload
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (pop) begin
         total_ff <= cmd_total;
         last_idx_ff <= AW'(cmd_total - CNTW'(2));
      end
      if (pop && cmd_ctrl.store) begin
         q1x_ff <= prevx_ff;
         q1y_ff <= prevy_ff;
         q2x_ff <= cmd_x;
         q2y_ff <= cmd_y;
         nx_ff <= dif(cmd_x, prevx_ff);
         ny_ff <= dif(cmd_y, prevy_ff);
         prevx_ff <= cmd_x;
         prevy_ff <= cmd_y;
      end
   end

   assign vjx = rdata_ff[VW-1:CW];
   assign vjy = rdata_ff[CW-1:0];

   assign pc0_in = ex_ff * ny_ff;
   assign pc1_in = ey_ff * nx_ff;
   assign pa0_in = ax_ff * dy_ff;
   assign pa1_in = ay_ff * dx_ff;
   assign pb0_in = bx_ff * dy_ff;
   assign pb1_in = by_ff * dx_ff;

   // scan pipeline: read, differences, products, signs, combine
   always_ff @(posedge clock) begin
      p1_first_ff <= rd_idx_ff == '0;
      p1_last_ff <= rd_idx_ff == last_idx_ff;

      p2_first_ff <= p1_first_ff;
      p2_last_ff <= p1_last_ff;
      if (p1_vld_ff) begin
         ux_ff <= vjx;
         uy_ff <= vjy;
      end
      ex_ff <= dif(vjx, q1x_ff);
      ey_ff <= dif(vjy, q1y_ff);
      dx_ff <= dif(vjx, ux_ff);
      dy_ff <= dif(vjy, uy_ff);
      ax_ff <= dif(q1x_ff, ux_ff);
      ay_ff <= dif(q1y_ff, uy_ff);
      bx_ff <= dif(q2x_ff, ux_ff);
      by_ff <= dif(q2y_ff, uy_ff);

      p3_first_ff <= p2_first_ff;
      p3_last_ff <= p2_last_ff;
      pc0_ff <= pc0_in;
      pc1_ff <= pc1_in;
      pa0_ff <= pa0_in;
      pa1_ff <= pa1_in;
      pb0_ff <= pb0_in;
      pb1_ff <= pb1_in;

      p4_first_ff <= p3_first_ff;
      p4_last_ff <= p3_last_ff;
      c_sg_ff <= sgn(pc0_ff, pc1_ff);
      a_sg_ff <= sgn(pa0_ff, pa1_ff);
      b_sg_ff <= sgn(pb0_ff, pb1_ff);

      if (p4_vld_ff) begin
         cprev_ff <= c_sg_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_direct) begin
         crosses_ff <= 1'b0;
         tot_out_ff <= TOTAL_BITS'(cmd_total);
         dropped_ff <= cmd_ctrl.dropped;
      end else if (done) begin
         crosses_ff <= hit_ff | hit_now;
         tot_out_ff <= TOTAL_BITS'(total_ff);
         dropped_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid = rsp_vld_ff;
   assign rsp_bus.crosses = crosses_ff;
   assign rsp_bus.vertex_total = tot_out_ff;
   assign rsp_bus.dropped = dropped_ff;

`ifndef SYNTHESIS
   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ST_IDLE && rsp_vld_ff)
      else $error("scan end did not deliver a result");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rd_idx_ff <= last_idx_ff)
      else $error("scan read past last stored vertex");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      p1_vld_ff |-> state_ff != ST_IDLE)
      else $error("scan pipeline active while idle");
`endif

endmodule
